>>> hdl/rsgsf_pkg.sv
// ----------------------------------------------------------------------------
// rsgsf_pkg
// Shared constants and types of the genotype site filter.
// ----------------------------------------------------------------------------
package rsgsf_pkg;

   // Field widths
   localparam int KIND_W  = 2;
   localparam int BASE_W  = 3;
   localparam int DEPTH_W = 16;
   localparam int TOT_W   = 17;
   localparam int GT_W    = 4;
   localparam int CSR_W   = 3;

   // Site counters
   localparam int MAX_SAMPLES = 4096;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = COUNT_W + 1;

   // 48-bit linear congruential generator
   localparam int            RNG_W     = 48;
   localparam int            RNG_MUL_W = 35;
   localparam int            RNG_CNT_W = $clog2(RNG_MUL_W);
   localparam logic [RNG_MUL_W-1:0] RNG_MUL  = 35'h5DEECE66D;
   localparam logic [RNG_W-1:0]     RNG_ADD  = 48'hB;
   localparam logic [RNG_W-1:0]     RNG_SEED = 48'd253405757471;
   localparam int            DRAW_LSB  = 17;
   localparam int            DRAW_W    = RNG_W - DRAW_LSB;
   localparam int            DIV_CNT_W = $clog2(DRAW_W);

   // Record kinds
   localparam logic [KIND_W-1:0] KIND_MISSING   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REF_ONLY  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BIALLELIC = 2'd2;

   // Base codes
   localparam logic [BASE_W-1:0] BASE_A    = 3'd0;
   localparam logic [BASE_W-1:0] BASE_C    = 3'd1;
   localparam logic [BASE_W-1:0] BASE_G    = 3'd2;
   localparam logic [BASE_W-1:0] BASE_T    = 3'd3;
   localparam logic [BASE_W-1:0] BASE_NONE = 3'd4;

   // Genotype codes
   localparam logic [GT_W-1:0] GT_ALT     = 4'd0;
   localparam logic [GT_W-1:0] GT_REF     = 4'd2;
   localparam logic [GT_W-1:0] GT_MISSING = 4'd9;

   // Register indexes
   localparam logic [CSR_W-1:0] CSR_DROP_TRANSITIONS   = 3'd0;
   localparam logic [CSR_W-1:0] CSR_DROP_MONOMORPHIC   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_DROP_SINGLETON     = 3'd2;
   localparam logic [CSR_W-1:0] CSR_DROP_UNINFORMATIVE = 3'd3;
   localparam logic [CSR_W-1:0] CSR_MAJORITY_CALL      = 3'd4;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic [GT_W-1:0]   gt;
      logic              need_draw;
      logic [BASE_W-1:0] site_ref;
      logic [BASE_W-1:0] site_alt;
      logic              site_rejected;
   } class_type;

endpackage

>>> hdl/read_sampling_genotype_site_filter.sv
// ----------------------------------------------------------------------------
// read_sampling_genotype_site_filter
// Haploid genotype call per sample from read counts, with a per-site verdict.
// ----------------------------------------------------------------------------
// Input channel req_*: one sample's read counts per item. Output channel
// rsp_*: one call per item; on the item flagged last_of_site, rsp_site_end
// is set and rsp_keep_site carries the site verdict. csr_*: write-only
// filter and call-mode bits, registered on write.
// Without a draw, an item passes from EVAL to FIN and then into the output
// register. With a drawn read it passes EVAL, DRAW (waiting for the
// generator), DIV (the serial remainder of the draw by the total depth)
// and FIN. The next generator state is prepared in the background (one
// multiplier bit per cycle), overlapping the remainder.
// One item is in work at a time; an item may be accepted while the previous
// result still sits in the output register. If rsp_ready stays low, the next
// result waits in the block and req_ready drops until it can move.
// Reset: synchronous; filter bits return to defaults, site state clears and
// the generator reloads its seed. The first draw waits until the successor
// state of the seed has been computed.
// ----------------------------------------------------------------------------
module read_sampling_genotype_site_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rsgsf_pkg::KIND_W-1:0]   req_sample_kind,
   input  logic                           req_record_reject,
   input  logic [rsgsf_pkg::BASE_W-1:0]   req_ref_base,
   input  logic [rsgsf_pkg::BASE_W-1:0]   req_alt_base,
   input  logic [rsgsf_pkg::DEPTH_W-1:0]  req_ref_depth,
   input  logic [rsgsf_pkg::DEPTH_W-1:0]  req_alt_depth,
   input  logic [rsgsf_pkg::TOT_W-1:0]    req_depth_limit,
   input  logic                           req_last_of_site,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rsgsf_pkg::GT_W-1:0]     rsp_genotype,
   output logic                           rsp_site_end,
   output logic                           rsp_keep_site,
   input  logic                           csr_write_en,
   input  logic [rsgsf_pkg::CSR_W-1:0]    csr_index,
   input  logic                           csr_wdata
);
   import rsgsf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_DRAW = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type st_ff, st_in;

   // configuration
   logic drop_transitions_ff, drop_monomorphic_ff, drop_singleton_ff;
   logic drop_uninformative_ff, majority_call_ff;

   // item registers
   logic [KIND_W-1:0]  item_kind_ff;
   logic               item_reject_ff;
   logic [BASE_W-1:0]  item_ref_base_ff, item_alt_base_ff;
   logic [DEPTH_W-1:0] item_ref_depth_ff, item_alt_depth_ff;
   logic [TOT_W-1:0]   item_limit_ff;
   logic               item_last_ff;
   logic [GT_W-1:0]    gt_ff, gt_in;

   // site state
   logic [COUNT_W-1:0] called_count_ff, called_count_in;
   logic [SUM_W-1:0]   genotype_sum_ff, genotype_sum_in;
   logic [BASE_W-1:0]  site_ref_ff, site_alt_ff;
   logic               site_rejected_ff;

   // output register
   logic               rsp_valid_ff;
   logic [GT_W-1:0]    rsp_genotype_ff;
   logic               rsp_site_end_ff, rsp_keep_site_ff;

   logic               accept, fin_go, counted, keep, transition;
   logic [TOT_W-1:0]   tot;
   logic [SUM_W-1:0]   full;
   logic               lcg_consume, lcg_ready;
   logic [DRAW_W-1:0]  draw;
   div_stat_type       div_stat;
   logic [TOT_W-1:0]   remainder;
   class_type          cls;

   assign accept = req_valid && req_ready;
   assign fin_go = (st_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign tot    = TOT_W'(item_ref_depth_ff) + TOT_W'(item_alt_depth_ff);

   // Call path; site state is unchanged from EVAL through FIN
   always_comb begin
      cls.gt            = GT_MISSING;
      cls.need_draw     = 1'b0;
      cls.site_ref      = site_ref_ff;
      cls.site_alt      = site_alt_ff;
      cls.site_rejected = site_rejected_ff;
      priority if (site_rejected_ff) begin
      end else if (item_kind_ff != KIND_REF_ONLY && item_kind_ff != KIND_BIALLELIC) begin
      end else if (item_reject_ff) begin
         cls.site_rejected = 1'b1;
      end else begin
         if (site_ref_ff == BASE_NONE) begin
            cls.site_ref = item_ref_base_ff;
         end
         priority if (item_kind_ff == KIND_REF_ONLY) begin
            cls.gt = (item_ref_depth_ff == '0) ? GT_MISSING : GT_REF;
         end else if (site_alt_ff != BASE_NONE && site_alt_ff != item_alt_base_ff) begin
            cls.site_rejected = 1'b1;
         end else begin
            if (site_alt_ff == BASE_NONE) begin
               cls.site_alt = item_alt_base_ff;
            end
            priority if (item_ref_depth_ff == '0) begin
               cls.gt = (item_alt_depth_ff != '0) ? GT_ALT : GT_MISSING;
            end else if (item_limit_ff != '0 && tot > item_limit_ff) begin
               cls.gt = GT_MISSING;
            end else if (majority_call_ff && item_ref_depth_ff > item_alt_depth_ff) begin
               cls.gt = GT_REF;
            end else if (majority_call_ff && item_ref_depth_ff < item_alt_depth_ff) begin
               cls.gt = GT_ALT;
            end else begin
               cls.need_draw = 1'b1;
            end
         end
      end
   end

   // Counters and verdict
   assign counted = (gt_ff != GT_MISSING) &&
                    (called_count_ff < COUNT_W'(MAX_SAMPLES));
   assign called_count_in = counted ? called_count_ff + COUNT_W'(1) : called_count_ff;
   assign genotype_sum_in = counted ? genotype_sum_ff + SUM_W'(gt_ff) : genotype_sum_ff;
   assign full            = {called_count_in, 1'b0};

   assign transition = (cls.site_ref == BASE_C && cls.site_alt == BASE_T) ||
                       (cls.site_ref == BASE_T && cls.site_alt == BASE_C) ||
                       (cls.site_ref == BASE_G && cls.site_alt == BASE_A) ||
                       (cls.site_ref == BASE_A && cls.site_alt == BASE_G);

   always_comb begin
      priority if (cls.site_rejected) begin
         keep = 1'b0;
      end else if (drop_monomorphic_ff && cls.site_alt == BASE_NONE) begin
         keep = 1'b0;
      end else if (drop_uninformative_ff && called_count_in == '0) begin
         keep = 1'b0;
      end else if (drop_monomorphic_ff &&
                   (genotype_sum_in == full || genotype_sum_in == '0)) begin
         keep = 1'b0;
      end else if (drop_singleton_ff &&
                   ((called_count_in != '0 && genotype_sum_in == full - SUM_W'(2)) ||
                    genotype_sum_in == SUM_W'(2))) begin
         keep = 1'b0;
      end else if (drop_transitions_ff && transition) begin
         keep = 1'b0;
      end else begin
         keep = 1'b1;
      end
   end

   // Sequencer
   always_comb begin
      st_in       = st_ff;
      gt_in       = gt_ff;
      lcg_consume = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            gt_in = cls.gt;
            st_in = cls.need_draw ? ST_DRAW : ST_FIN;
         end
         ST_DRAW: begin
            if (lcg_ready) begin
               lcg_consume = 1'b1;
               st_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               gt_in = (remainder < TOT_W'(item_ref_depth_ff)) ? GT_REF : GT_ALT;
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_go) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   rsgsf_lcg u_lcg (
      .clock   (clock),
      .reset   (reset),
      .consume (lcg_consume),
      .ready   (lcg_ready),
      .draw    (draw)
   );

   rsgsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (lcg_consume),
      .dividend  (draw),
      .divisor   (tot),
      .stat      (div_stat),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff                 <= ST_IDLE;
         drop_transitions_ff   <= 1'b0;
         drop_monomorphic_ff   <= 1'b1;
         drop_singleton_ff     <= 1'b1;
         drop_uninformative_ff <= 1'b1;
         majority_call_ff      <= 1'b0;
         called_count_ff       <= '0;
         genotype_sum_ff       <= '0;
         site_ref_ff           <= BASE_NONE;
         site_alt_ff           <= BASE_NONE;
         site_rejected_ff      <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_DROP_TRANSITIONS:   drop_transitions_ff   <= csr_wdata;
               CSR_DROP_MONOMORPHIC:   drop_monomorphic_ff   <= csr_wdata;
               CSR_DROP_SINGLETON:     drop_singleton_ff     <= csr_wdata;
               CSR_DROP_UNINFORMATIVE: drop_uninformative_ff <= csr_wdata;
               CSR_MAJORITY_CALL:      majority_call_ff      <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
            if (item_last_ff) begin
               called_count_ff  <= '0;
               genotype_sum_ff  <= '0;
               site_ref_ff      <= BASE_NONE;
               site_alt_ff      <= BASE_NONE;
               site_rejected_ff <= 1'b0;
            end else begin
               called_count_ff  <= called_count_in;
               genotype_sum_ff  <= genotype_sum_in;
               site_ref_ff      <= cls.site_ref;
               site_alt_ff      <= cls.site_alt;
               site_rejected_ff <= cls.site_rejected;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      gt_ff <= gt_in;
      if (accept) begin
         item_kind_ff      <= req_sample_kind;
         item_reject_ff    <= req_record_reject;
         item_ref_base_ff  <= req_ref_base;
         item_alt_base_ff  <= req_alt_base;
         item_ref_depth_ff <= req_ref_depth;
         item_alt_depth_ff <= req_alt_depth;
         item_limit_ff     <= req_depth_limit;
         item_last_ff      <= req_last_of_site;
      end
      if (fin_go) begin
         rsp_genotype_ff  <= gt_ff;
         rsp_site_end_ff  <= item_last_ff;
         rsp_keep_site_ff <= item_last_ff && keep;
      end
   end

   assign req_ready     = (st_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_genotype  = rsp_genotype_ff;
   assign rsp_site_end  = rsp_site_end_ff;
   assign rsp_keep_site = rsp_keep_site_ff;

   // Assertions
   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("remainder unit idle while a draw is pending");

   a_fin_output: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> rsp_valid)
      else $error("finished item did not reach the output register");

   a_keep_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_site_end) |-> !rsp_keep_site)
      else $error("verdict raised on a result that does not close a site");

   a_site_clear: assert property (@(posedge clock) disable iff (reset)
      (fin_go && item_last_ff) |=>
         (called_count_ff == '0 && site_ref_ff == BASE_NONE && !site_rejected_ff))
      else $error("site state not cleared after the last sample");

endmodule

>>> hdl/rsgsf_lcg.sv
// ----------------------------------------------------------------------------
// rsgsf_lcg
// Random draw source: computes the next 48-bit generator state ahead of use,
// one multiplier bit per cycle (shift and add).
// ----------------------------------------------------------------------------
module rsgsf_lcg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         consume,
   output logic                         ready,
   output logic [rsgsf_pkg::DRAW_W-1:0] draw
);
   import rsgsf_pkg::*;

   logic [RNG_W-1:0]     x_ff, x_in;
   logic [RNG_W-1:0]     acc_ff, acc_in;
   logic [RNG_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      x_in    = x_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (RNG_MUL[cnt_ff]) begin
            acc_in = acc_ff + x_ff;
         end
         x_in   = {x_ff[RNG_W-2:0], 1'b0};
         cnt_in = cnt_ff + RNG_CNT_W'(1);
         if (cnt_ff == RNG_CNT_W'(RNG_MUL_W - 1)) begin
            busy_in = 1'b0;
         end
      end else if (consume) begin
         // current result becomes the state; start on its successor
         x_in    = acc_ff;
         acc_in  = RNG_ADD;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= RNG_SEED;
         acc_ff  <= RNG_ADD;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         x_ff    <= x_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign ready = !busy_ff;
   assign draw  = acc_ff[RNG_W-1:DRAW_LSB];

endmodule

>>> hdl/rsgsf_div.sv
// ----------------------------------------------------------------------------
// rsgsf_div
// Serial restoring remainder: 31-bit draw modulo 17-bit total depth,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsgsf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rsgsf_pkg::DRAW_W-1:0] dividend,
   input  logic [rsgsf_pkg::TOT_W-1:0]  divisor,
   output rsgsf_pkg::div_stat_type      stat,
   output logic [rsgsf_pkg::TOT_W-1:0]  remainder
);
   import rsgsf_pkg::*;

   logic [DRAW_W-1:0]    num_ff, num_in;
   logic [TOT_W-1:0]     den_ff, den_in;
   logic [TOT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [TOT_W:0]       trial;

   assign trial = {rem_ff, num_ff[DRAW_W-1]};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         num_in = {num_ff[DRAW_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = TOT_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[TOT_W-1:0];
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DRAW_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for read_sampling_genotype_site_filter.
// ----------------------------------------------------------------------------
// Sample items go in over req_*, with random gaps. Calls come back over rsp_*,
// with random stalls. A behavioral copy of the caller (its own generator,
// site bookkeeping and filter verdict) predicts each call at acceptance, and
// the checker compares every result with the oldest prediction. The tests:
// directed call paths, site rejection, call modes with only the transition
// filter on, then random sites over several filter settings.
// ----------------------------------------------------------------------------
module tb_top;
   import rsgsf_pkg::*;

   localparam int              SAMPLE_CAP  = 4096;
   localparam logic [47:0]     LCG_MUL     = 48'h5DEECE66D;
   localparam logic [47:0]     LCG_INC     = 48'hB;
   localparam logic [47:0]     LCG_SEED    = 48'd253405757471;
   localparam int              MAX_GAP     = 16;
   localparam int              TAIL_CYCLES = 60;
   localparam int              LIMIT_MAX   = (1 << TOT_W) - 1;
   localparam int              PHASE_ITEMS = 125;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic               record_reject;
      logic [BASE_W-1:0]  ref_base;
      logic [BASE_W-1:0]  alt_base;
      logic [DEPTH_W-1:0] ref_depth;
      logic [DEPTH_W-1:0] alt_depth;
      logic [TOT_W-1:0]   depth_limit;
      logic               last;
   } sample_item_type;

   typedef struct {
      logic [GT_W-1:0] genotype;
      logic            site_end;
      logic            keep_site;
   } site_call_type;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_ready;
   logic [KIND_W-1:0]  req_sample_kind   = '0;
   logic               req_record_reject = 1'b0;
   logic [BASE_W-1:0]  req_ref_base      = '0;
   logic [BASE_W-1:0]  req_alt_base      = '0;
   logic [DEPTH_W-1:0] req_ref_depth     = '0;
   logic [DEPTH_W-1:0] req_alt_depth     = '0;
   logic [TOT_W-1:0]   req_depth_limit   = '0;
   logic               req_last_of_site  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready         = 1'b0;
   logic [GT_W-1:0]    rsp_genotype;
   logic               rsp_site_end;
   logic               rsp_keep_site;
   logic               csr_write_en      = 1'b0;
   logic [CSR_W-1:0]   csr_index         = '0;
   logic               csr_wdata         = 1'b0;

   read_sampling_genotype_site_filter uut (.*);

   always #5 clock = ~clock;

   // filter settings and site state of the predictor
   bit          cfg_drop_ti;
   bit          cfg_drop_mono;
   bit          cfg_drop_single;
   bit          cfg_drop_uninf;
   bit          cfg_majority;
   logic [47:0] lcg_state;
   int          site_gt_sum;
   int          site_called;
   logic [BASE_W-1:0] first_ref;
   logic [BASE_W-1:0] first_alt;
   bit          site_dropped;

   site_call_type expected_calls[$];
   int          error_count;
   int          fed_count;
   int          ready_hold;
   bit          feed_calm;
   bit          sink_calm;

   function automatic int pick_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void clear_site();
      site_gt_sum  = 0;
      site_called  = 0;
      first_ref    = BASE_NONE;
      first_alt    = BASE_NONE;
      site_dropped = 1'b0;
   endfunction

   function automatic logic [GT_W-1:0] call_genotype(input sample_item_type s);
      logic [TOT_W-1:0] total;
      logic [30:0]      draw;
      if (site_dropped)
         return GT_MISSING;
      if (s.kind != KIND_REF_ONLY && s.kind != KIND_BIALLELIC)
         return GT_MISSING;
      if (s.record_reject) begin
         site_dropped = 1'b1;
         return GT_MISSING;
      end
      if (first_ref == BASE_NONE)
         first_ref = s.ref_base;
      if (s.kind == KIND_REF_ONLY)
         return (s.ref_depth == 0) ? GT_MISSING : GT_REF;
      if (first_alt == BASE_NONE) begin
         first_alt = s.alt_base;
      end else if (first_alt != s.alt_base) begin
         site_dropped = 1'b1;
         return GT_MISSING;
      end
      if (s.ref_depth == 0)
         return (s.alt_depth != 0) ? GT_ALT : GT_MISSING;
      total = TOT_W'(s.ref_depth) + TOT_W'(s.alt_depth);
      if (s.depth_limit != 0 && total > s.depth_limit)
         return GT_MISSING;
      if (cfg_majority) begin
         if (s.ref_depth > s.alt_depth)
            return GT_REF;
         if (s.ref_depth < s.alt_depth)
            return GT_ALT;
      end
      lcg_state = lcg_state * LCG_MUL + LCG_INC;
      draw = lcg_state[47:17];
      return ((draw % total) < s.ref_depth) ? GT_REF : GT_ALT;
   endfunction

   function automatic logic judge_site();
      int full;
      bit transition;
      full = 2 * site_called;
      if (site_dropped)
         return 1'b0;
      if (cfg_drop_mono && first_alt == BASE_NONE)
         return 1'b0;
      if (cfg_drop_uninf && site_called == 0)
         return 1'b0;
      if (cfg_drop_mono && (site_gt_sum == full || site_gt_sum == 0))
         return 1'b0;
      if (cfg_drop_single &&
          ((site_called >= 1 && site_gt_sum == full - 2) || site_gt_sum == 2))
         return 1'b0;
      transition = (first_ref == BASE_C && first_alt == BASE_T) ||
                   (first_ref == BASE_T && first_alt == BASE_C) ||
                   (first_ref == BASE_G && first_alt == BASE_A) ||
                   (first_ref == BASE_A && first_alt == BASE_G);
      if (cfg_drop_ti && transition)
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic site_call_type predict_call(input sample_item_type s);
      site_call_type c;
      c.genotype = call_genotype(s);
      if (c.genotype != GT_MISSING && site_called < SAMPLE_CAP) begin
         site_called++;
         site_gt_sum += c.genotype;
      end
      c.site_end  = s.last;
      c.keep_site = 1'b0;
      if (s.last) begin
         c.keep_site = judge_site();
         clear_site();
      end
      return c;
   endfunction

   function automatic sample_item_type build_sample(
      input logic [KIND_W-1:0] kind, input logic rejected,
      input logic [BASE_W-1:0] rb, input logic [BASE_W-1:0] ab,
      input int dr, input int da, input int lim, input logic last);
      sample_item_type s;
      s.kind          = kind;
      s.record_reject = rejected;
      s.ref_base      = rb;
      s.alt_base      = ab;
      s.ref_depth     = DEPTH_W'(dr);
      s.alt_depth     = DEPTH_W'(da);
      s.depth_limit   = TOT_W'(lim);
      s.last          = last;
      return s;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 100)
         $display("tb_top: %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic send_sample(input sample_item_type s);
      int gap;
      gap = pick_gap(feed_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_kind   <= s.kind;
      req_record_reject <= s.record_reject;
      req_ref_base      <= s.ref_base;
      req_alt_base      <= s.alt_base;
      req_ref_depth     <= s.ref_depth;
      req_alt_depth     <= s.alt_depth;
      req_depth_limit   <= s.depth_limit;
      req_last_of_site  <= s.last;
      do @(posedge clock); while (!req_ready);
      expected_calls.push_back(predict_call(s));
      fed_count++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_calls.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_filters(input bit drop_ti, input bit drop_mono,
                              input bit drop_single, input bit drop_uninf,
                              input bit majority);
      logic [CSR_MAJORITY_CALL:0] value_of;
      int idx;
      value_of = {majority, drop_uninf, drop_single, drop_mono, drop_ti};
      for (idx = CSR_DROP_TRANSITIONS; idx <= CSR_MAJORITY_CALL; idx++) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= CSR_W'(idx);
         csr_wdata    <= value_of[idx];
      end
      // unmapped index, must have no effect
      @(negedge clock);
      csr_index <= CSR_W'($urandom_range(CSR_MAJORITY_CALL + 1, (1 << CSR_W) - 1));
      csr_wdata <= 1'($urandom);
      @(negedge clock);
      csr_write_en    <= 1'b0;
      cfg_drop_ti     = drop_ti;
      cfg_drop_mono   = drop_mono;
      cfg_drop_single = drop_single;
      cfg_drop_uninf  = drop_uninf;
      cfg_majority    = majority;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      site_call_type exp_call;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_calls.size() == 0) begin
            report_mismatch($sformatf("unexpected item gt=%0d end=%0d keep=%0d",
                            rsp_genotype, rsp_site_end, rsp_keep_site));
         end else begin
            exp_call = expected_calls.pop_front();
            if (rsp_genotype !== exp_call.genotype)
               report_mismatch($sformatf("genotype %0d, expected %0d",
                               rsp_genotype, exp_call.genotype));
            if (rsp_site_end !== exp_call.site_end)
               report_mismatch($sformatf("site_end %0b, expected %0b",
                               rsp_site_end, exp_call.site_end));
            if (rsp_keep_site !== exp_call.keep_site)
               report_mismatch($sformatf("keep_site %0b, expected %0b",
                               rsp_keep_site, exp_call.keep_site));
         end
         ready_hold = pick_gap(sink_calm);
      end
   end

   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // reset filter settings, every call path but the majority calls
   task automatic test_call_paths();
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 5, 7, 0, 0));
      send_sample(build_sample(KIND_REF_ONLY, 0, BASE_A, BASE_NONE, 0, 3, 0, 0));
      send_sample(build_sample(KIND_REF_ONLY, 0, BASE_G, 7, 65535, 65535, 1, 0));
      send_sample(build_sample(KIND_MISSING, 1, BASE_C, BASE_T, 4, 4, 0, 0));
      send_sample(build_sample(2'b11, 0, BASE_C, BASE_T, 4, 4, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 0, 65535, 1, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 0, 0, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, 7, BASE_T, 65535, 65535,
                               LIMIT_MAX, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 10, 10, 19, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 1, 1, 2, 1));
      settle();
   endtask

   // alt mismatch, record reject, unset alt, empty site
   task automatic test_site_rejection();
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_A, BASE_G, 3, 4, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_A, BASE_C, 3, 4, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_A, BASE_G, 5, 5, 0, 0));
      send_sample(build_sample(KIND_REF_ONLY, 0, BASE_A, BASE_G, 3, 0, 0, 1));
      send_sample(build_sample(KIND_REF_ONLY, 1, BASE_T, BASE_G, 3, 0, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_T, BASE_G, 2, 6, 0, 1));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_G, BASE_NONE, 4, 2, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_G, BASE_A, 2, 9, 0, 1));
      send_sample(build_sample(KIND_MISSING, 0, BASE_G, BASE_A, 2, 9, 0, 1));
      settle();
   endtask

   // majority calls and ties, filters relaxed
   task automatic test_call_modes();
      set_filters(1, 0, 0, 0, 1);
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 8, 3, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 3, 8, 0, 0));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_C, BASE_T, 4, 4, 0, 1));
      send_sample(build_sample(KIND_BIALLELIC, 0, BASE_A, BASE_C, 1, 2, 0, 1));
      send_sample(build_sample(KIND_MISSING, 0, BASE_A, BASE_C, 1, 2, 0, 1));
      settle();
   endtask

   function automatic logic [BASE_W-1:0] pick_base();
      int r;
      r = $urandom_range(0, 19);
      if (r < 16)
         return BASE_W'($urandom_range(BASE_A, BASE_T));
      if (r < 18)
         return BASE_NONE;
      return BASE_W'($urandom);
   endfunction

   function automatic int pick_depth();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return 0;
      if (r < 75)
         return $urandom_range(1, 20);
      if (r < 90)
         return $urandom_range(0, 255);
      return $urandom_range(0, (1 << DEPTH_W) - 1);
   endfunction

   function automatic sample_item_type site_sample(input logic [BASE_W-1:0] rb,
                                                   input logic [BASE_W-1:0] ab);
      sample_item_type s;
      int r;
      int t;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         s.kind          = KIND_W'($urandom);
         s.record_reject = 1'($urandom);
         s.ref_base      = BASE_W'($urandom);
         s.alt_base      = BASE_W'($urandom);
         s.ref_depth     = DEPTH_W'($urandom);
         s.alt_depth     = DEPTH_W'($urandom);
         s.depth_limit   = TOT_W'($urandom);
         return s;
      end
      s.kind = (r < 55) ? KIND_BIALLELIC : (r < 85) ? KIND_REF_ONLY :
               (r < 95) ? KIND_MISSING : KIND_W'($urandom);
      s.record_reject = ($urandom_range(0, 59) == 0);
      s.ref_base  = ($urandom_range(0, 9) == 0) ? pick_base() : rb;
      s.alt_base  = ($urandom_range(0, 39) == 0) ? pick_base() : ab;
      s.ref_depth = DEPTH_W'(pick_depth());
      s.alt_depth = DEPTH_W'(pick_depth());
      r = $urandom_range(0, 9);
      if (r < 5) begin
         t = 0;
      end else if (r < 8) begin
         t = int'(s.ref_depth) + int'(s.alt_depth) + $urandom_range(0, 4) - 2;
         if (t < 0)
            t = 0;
         if (t > LIMIT_MAX)
            t = LIMIT_MAX;
      end else begin
         t = $urandom_range(0, LIMIT_MAX);
      end
      s.depth_limit = TOT_W'(t);
      return s;
   endfunction

   task automatic run_site(input int n_samples);
      logic [BASE_W-1:0] rb;
      logic [BASE_W-1:0] ab;
      sample_item_type s;
      int idx;
      rb = pick_base();
      ab = pick_base();
      for (idx = 0; idx < n_samples; idx++) begin
         s = site_sample(rb, ab);
         s.last = (idx == n_samples - 1);
         send_sample(s);
      end
   endtask

   task automatic test_random_sites();
      int phase;
      int phase_end;
      int r;
      for (phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            set_filters(0, 0, 0, 0, 0);
         else if (phase == 1)
            set_filters(1, 1, 1, 1, 1);
         else
            set_filters(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom));
         feed_calm = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         phase_end = fed_count + PHASE_ITEMS;
         while (fed_count < phase_end) begin
            if ($urandom_range(0, 7) == 0)
               feed_calm = !feed_calm;
            if ($urandom_range(0, 7) == 0)
               sink_calm = !sink_calm;
            r = $urandom_range(0, 19);
            if (r < 2)
               run_site(1);
            else if (r < 18)
               run_site($urandom_range(2, 10));
            else
               run_site($urandom_range(11, 24));
         end
         settle();
      end
   endtask

   initial begin
      cfg_drop_ti     = 1'b0;
      cfg_drop_mono   = 1'b1;
      cfg_drop_single = 1'b1;
      cfg_drop_uninf  = 1'b1;
      cfg_majority    = 1'b0;
      lcg_state       = LCG_SEED;
      clear_site();
      error_count = 0;
      fed_count   = 0;
      ready_hold  = 0;
      feed_calm   = 1'b0;
      sink_calm   = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_call_paths();
      test_site_rejection();
      test_call_modes();
      test_random_sites();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #25_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
